@@ design/rvde_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// RV32I decode/execute package
// Shared codes, constants and the item types passed between the front end,
// the decoupling queue and the execute back end.
// ============================================================================
package rvde_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [31:0] HALT_WORD = 32'h0FF0_0513;
    localparam logic [31:0] PC_STEP   = 32'd4;
    localparam logic [31:0] UIMM_MASK = 32'hFFFF_F000;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 values
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_LD_W   = 3'd2;
    localparam logic [2:0] F3_LD_BAD = 3'd3;
    localparam logic [2:0] F3_LD_HU  = 3'd5;
    localparam logic [2:0] F3_ST_W   = 3'd2;
    localparam logic [2:0] F3_JALR   = 3'd0;

    // Branch conditions (funct3 of a branch)
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_RS2 = 3'd2;
    localparam logic [2:0] BR_RS3 = 3'd3;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    // Operation classes as seen on the result side
    localparam logic [2:0] CLS_ALU     = 3'd0;
    localparam logic [2:0] CLS_LOAD    = 3'd1;
    localparam logic [2:0] CLS_STORE   = 3'd2;
    localparam logic [2:0] CLS_BRANCH  = 3'd3;
    localparam logic [2:0] CLS_JUMP    = 3'd4;
    localparam logic [2:0] CLS_INVALID = 3'd5;

    // ALU operations chosen by the front end
    localparam logic [3:0] ALU_ZERO = 4'd0;
    localparam logic [3:0] ALU_ADD  = 4'd1;
    localparam logic [3:0] ALU_SUB  = 4'd2;
    localparam logic [3:0] ALU_SLL  = 4'd3;
    localparam logic [3:0] ALU_SLT  = 4'd4;
    localparam logic [3:0] ALU_SLTU = 4'd5;
    localparam logic [3:0] ALU_XOR  = 4'd6;
    localparam logic [3:0] ALU_SRL  = 4'd7;
    localparam logic [3:0] ALU_SRA  = 4'd8;
    localparam logic [3:0] ALU_OR   = 4'd9;
    localparam logic [3:0] ALU_AND  = 4'd10;

    // Decoded item handed from the front end to the back end
    typedef struct packed {
        logic [2:0]  op_class;
        logic        halt;
        logic [4:0]  dest_reg;
        logic        writes_reg;
        logic [3:0]  alu_op;
        logic [31:0] opnd_a;
        logic [31:0] opnd_b;
        logic        is_branch;
        logic [2:0]  br_cond;
        logic        is_jump;
        logic        is_jalr;
        logic        is_mem;
        logic [31:0] tgt_base;
        logic [31:0] imm;
        logic [31:0] pc;
        logic [1:0]  mem_size;
        logic        load_unsigned;
        logic [31:0] store_data;
    } dec_item_t;

    // Finished result item
    typedef struct packed {
        logic [2:0]  op_class;
        logic [4:0]  dest_reg;
        logic        writes_reg;
        logic [31:0] result_value;
        logic        branch_taken;
        logic [31:0] next_pc;
        logic [31:0] mem_address;
        logic [1:0]  mem_size;
        logic        load_unsigned;
        logic [31:0] store_data;
        logic        halt;
    } result_t;

endpackage

@@ design/rvde_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// RV32I decode front end
// Accepts instruction items, classifies them, selects operands and
// immediates, and holds the decoded item until the queue takes it.
// ============================================================================
module rvde_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [31:0]        instruction,
    input  logic [31:0]        inst_pc,
    input  logic [31:0]        src1_value,
    input  logic [31:0]        src2_value,
    output logic               q_push,
    output rvde_pkg::dec_item_t q_item,
    input  logic               q_full
);
    import rvde_pkg::*;

    logic       front_valid_reg;
    logic       front_valid_next;
    dec_item_t  front_item_reg;
    dec_item_t  dec;
    logic       accept;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic        wr;
    logic        alu_ok;
    logic [3:0]  alu_sel;

    assign opc = instruction[6:0];
    assign rd  = instruction[11:7];
    assign f3  = instruction[14:12];
    assign f7  = instruction[31:25];

    assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_b = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                    instruction[11:8], 1'b0};
    assign imm_j = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                    instruction[30:21], 1'b0};
    assign imm_u = instruction & UIMM_MASK;

    // ALU operation and funct7 check shared by the immediate and register forms.
    always_comb
    begin
        alu_ok  = 1'b0;
        alu_sel = ALU_ZERO;
        case (f3)
            F3_ADD:
            begin
                if (opc == OPC_OP_IMM)
                begin
                    alu_ok  = 1'b1;
                    alu_sel = ALU_ADD;
                end
                else
                begin
                    alu_ok  = (f7 == F7_BASE) || (f7 == F7_ALT);
                    alu_sel = (f7 == F7_ALT) ? ALU_SUB : ALU_ADD;
                end
            end
            F3_SLL:
            begin
                alu_ok  = (f7 == F7_BASE);
                alu_sel = ALU_SLL;
            end
            F3_SR:
            begin
                alu_ok  = (f7 == F7_BASE) || (f7 == F7_ALT);
                alu_sel = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
            end
            F3_SLT:
            begin
                alu_ok  = (opc == OPC_OP_IMM) || (f7 == F7_BASE);
                alu_sel = ALU_SLT;
            end
            F3_SLTU:
            begin
                alu_ok  = (opc == OPC_OP_IMM) || (f7 == F7_BASE);
                alu_sel = ALU_SLTU;
            end
            F3_XOR:
            begin
                alu_ok  = (opc == OPC_OP_IMM) || (f7 == F7_BASE);
                alu_sel = ALU_XOR;
            end
            F3_OR:
            begin
                alu_ok  = (opc == OPC_OP_IMM) || (f7 == F7_BASE);
                alu_sel = ALU_OR;
            end
            default:
            begin
                alu_ok  = (opc == OPC_OP_IMM) || (f7 == F7_BASE);
                alu_sel = ALU_AND;
            end
        endcase
    end

    always_comb
    begin
        dec               = '0;
        dec.op_class      = CLS_INVALID;
        dec.alu_op        = ALU_ZERO;
        dec.br_cond       = f3;
        dec.pc            = inst_pc;
        wr                = 1'b0;

        if (instruction == HALT_WORD)
        begin
            dec.op_class = CLS_ALU;
            dec.halt     = 1'b1;
        end
        else
        begin
            case (opc)
                OPC_LUI:
                begin
                    dec.op_class = CLS_ALU;
                    wr           = 1'b1;
                    dec.alu_op   = ALU_ADD;
                    dec.opnd_b   = imm_u;
                end
                OPC_AUIPC:
                begin
                    dec.op_class = CLS_ALU;
                    wr           = 1'b1;
                    dec.alu_op   = ALU_ADD;
                    dec.opnd_a   = inst_pc;
                    dec.opnd_b   = imm_u;
                end
                OPC_JAL:
                begin
                    dec.op_class = CLS_JUMP;
                    wr           = 1'b1;
                    dec.alu_op   = ALU_ADD;
                    dec.opnd_a   = inst_pc;
                    dec.opnd_b   = PC_STEP;
                    dec.is_jump  = 1'b1;
                    dec.tgt_base = inst_pc;
                    dec.imm      = imm_j;
                end
                OPC_JALR:
                begin
                    if (f3 == F3_JALR)
                    begin
                        dec.op_class = CLS_JUMP;
                        wr           = 1'b1;
                        dec.alu_op   = ALU_ADD;
                        dec.opnd_a   = inst_pc;
                        dec.opnd_b   = PC_STEP;
                        dec.is_jump  = 1'b1;
                        dec.is_jalr  = 1'b1;
                        dec.tgt_base = src1_value;
                        dec.imm      = imm_i;
                    end
                end
                OPC_BRANCH:
                begin
                    if ((f3 != BR_RS2) && (f3 != BR_RS3))
                    begin
                        dec.op_class  = CLS_BRANCH;
                        dec.is_branch = 1'b1;
                        dec.opnd_a    = src1_value;
                        dec.opnd_b    = src2_value;
                        dec.tgt_base  = inst_pc;
                        dec.imm       = imm_b;
                    end
                end
                OPC_LOAD:
                begin
                    if ((f3 != F3_LD_BAD) && (f3 <= F3_LD_HU))
                    begin
                        dec.op_class      = CLS_LOAD;
                        wr                = 1'b1;
                        dec.is_mem        = 1'b1;
                        dec.tgt_base      = src1_value;
                        dec.imm           = imm_i;
                        dec.mem_size      = f3[1:0];
                        dec.load_unsigned = f3[2];
                    end
                end
                OPC_STORE:
                begin
                    if (f3 <= F3_ST_W)
                    begin
                        dec.op_class   = CLS_STORE;
                        dec.is_mem     = 1'b1;
                        dec.tgt_base   = src1_value;
                        dec.imm        = imm_s;
                        dec.mem_size   = f3[1:0];
                        dec.store_data = src2_value;
                    end
                end
                OPC_OP_IMM:
                begin
                    if (alu_ok)
                    begin
                        dec.op_class = CLS_ALU;
                        wr           = 1'b1;
                        dec.alu_op   = alu_sel;
                        dec.opnd_a   = src1_value;
                        dec.opnd_b   = imm_i;
                    end
                end
                OPC_OP:
                begin
                    if (alu_ok)
                    begin
                        dec.op_class = CLS_ALU;
                        wr           = 1'b1;
                        dec.alu_op   = alu_sel;
                        dec.opnd_a   = src1_value;
                        dec.opnd_b   = src2_value;
                    end
                end
                default:
                begin
                    dec.op_class = CLS_INVALID;
                end
            endcase
        end

        dec.dest_reg   = wr ? rd : 5'd0;
        dec.writes_reg = wr && (rd != 5'd0);
    end

    // The decoded item moves on as soon as the queue has room.
    assign q_push = front_valid_reg && !q_full;
    assign full   = front_valid_reg && q_full;
    assign accept = push && !full;
    assign q_item = front_item_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_item_reg <= dec;
        end
    end

endmodule

@@ design/rvde_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Decoupling queue
// A short FIFO of decoded items between the front end and the back end.
// ============================================================================
module rvde_queue
#(
    parameter int DEPTH = rvde_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rvde_pkg::dec_item_t push_item,
    output logic                full,
    input  logic                pop,
    output rvde_pkg::dec_item_t pop_item,
    output logic                empty
);
    import rvde_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dec_item_t          entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");
`endif

endmodule

@@ design/rvde_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// RV32I execute back end
// Takes decoded items from the queue, runs the ALU, branch compare and
// target adder, and holds the finished result until it is popped.
// ============================================================================
module rvde_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  rvde_pkg::dec_item_t q_item,
    output logic                q_pop,
    output logic                out_valid,
    output rvde_pkg::result_t   out_result,
    input  logic                pop
);
    import rvde_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;
    result_t     res;
    logic [31:0] alu_out;
    logic [4:0]  shamt;
    logic        cond;
    logic        taken;
    logic [31:0] tgt_sum;
    logic [31:0] target;
    logic [31:0] pc_plus4;

    assign shamt = q_item.opnd_b[4:0];

    always_comb
    begin
        case (q_item.alu_op)
            ALU_ADD:  alu_out = q_item.opnd_a + q_item.opnd_b;
            ALU_SUB:  alu_out = q_item.opnd_a - q_item.opnd_b;
            ALU_SLL:  alu_out = q_item.opnd_a << shamt;
            ALU_SLT:  alu_out = {31'd0, $signed(q_item.opnd_a) < $signed(q_item.opnd_b)};
            ALU_SLTU: alu_out = {31'd0, q_item.opnd_a < q_item.opnd_b};
            ALU_XOR:  alu_out = q_item.opnd_a ^ q_item.opnd_b;
            ALU_SRL:  alu_out = q_item.opnd_a >> shamt;
            ALU_SRA:  alu_out = 32'($signed(q_item.opnd_a) >>> shamt);
            ALU_OR:   alu_out = q_item.opnd_a | q_item.opnd_b;
            ALU_AND:  alu_out = q_item.opnd_a & q_item.opnd_b;
            default:  alu_out = 32'd0;
        endcase
    end

    always_comb
    begin
        case (q_item.br_cond)
            BR_EQ:   cond = (q_item.opnd_a == q_item.opnd_b);
            BR_NE:   cond = (q_item.opnd_a != q_item.opnd_b);
            BR_LT:   cond = ($signed(q_item.opnd_a) < $signed(q_item.opnd_b));
            BR_GE:   cond = ($signed(q_item.opnd_a) >= $signed(q_item.opnd_b));
            BR_LTU:  cond = (q_item.opnd_a < q_item.opnd_b);
            BR_GEU:  cond = (q_item.opnd_a >= q_item.opnd_b);
            default: cond = 1'b0;
        endcase
    end

    // The same adder gives the jump or branch target and the memory address.
    assign tgt_sum  = q_item.tgt_base + q_item.imm;
    assign target   = {tgt_sum[31:1], tgt_sum[0] & !q_item.is_jalr};
    assign pc_plus4 = q_item.pc + PC_STEP;
    assign taken    = q_item.is_jump || (q_item.is_branch && cond);

    always_comb
    begin
        res.op_class      = q_item.op_class;
        res.dest_reg      = q_item.dest_reg;
        res.writes_reg    = q_item.writes_reg;
        res.result_value  = alu_out;
        res.branch_taken  = taken;
        res.next_pc       = taken ? target : pc_plus4;
        res.mem_address   = q_item.is_mem ? tgt_sum : 32'd0;
        res.mem_size      = q_item.mem_size;
        res.load_unsigned = q_item.load_unsigned;
        res.store_data    = q_item.store_data;
        res.halt          = q_item.halt;
    end

    // A new item enters the output register whenever it is free or being emptied.
    assign q_pop = !q_empty && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

`ifndef SYNTHESIS
    a_write_has_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.writes_reg) |-> (out_reg.dest_reg != 5'd0))
        else $error("register write without a destination");

    a_halt_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.halt) |->
            ((out_reg.op_class == CLS_ALU) && !out_reg.writes_reg &&
             (out_reg.result_value == 32'd0) && !out_reg.branch_taken))
        else $error("halt item carries side effects");
`endif

endmodule

@@ design/rv32i_decode_execute.sv @@
`timescale 1ns / 1ps
// ============================================================================
// RV32I decode and execute unit
// Decodes one RV32I instruction item per cycle while full is low and returns its ALU result,
// branch decision, next pc and load/store attributes.
// ============================================================================
// The unit accepts one instruction item per clock and delivers one result
// item per clock in steady state while results are popped. An accepted item
// is decoded into the front register, moves through a QUEUE_DEPTH-entry
// queue and is executed into the output register, which drives the result
// ports. The queue lets the decode front end keep accepting items while
// results are not popped; full rises once the queue and the front register
// are both occupied.
module rv32i_decode_execute
#(
    parameter int QUEUE_DEPTH = rvde_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] instruction,
    input  logic [31:0] inst_pc,
    input  logic [31:0] src1_value,
    input  logic [31:0] src2_value,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  op_class,
    output logic [4:0]  dest_reg,
    output logic        writes_reg,
    output logic [31:0] result_value,
    output logic        branch_taken,
    output logic [31:0] next_pc,
    output logic [31:0] mem_address,
    output logic [1:0]  mem_size,
    output logic        load_unsigned,
    output logic [31:0] store_data,
    output logic        halt
);
    import rvde_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    dec_item_t  q_in_item;
    dec_item_t  q_out_item;
    logic       out_valid;
    result_t    out_result;

    rvde_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .instruction (instruction),
        .inst_pc     (inst_pc),
        .src1_value  (src1_value),
        .src2_value  (src2_value),
        .q_push      (q_push),
        .q_item      (q_in_item),
        .q_full      (q_full)
    );

    rvde_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .empty     (q_empty)
    );

    rvde_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (q_out_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_result (out_result),
        .pop        (pop)
    );

    assign empty         = !out_valid;
    assign op_class      = out_result.op_class;
    assign dest_reg      = out_result.dest_reg;
    assign writes_reg    = out_result.writes_reg;
    assign result_value  = out_result.result_value;
    assign branch_taken  = out_result.branch_taken;
    assign next_pc       = out_result.next_pc;
    assign mem_address   = out_result.mem_address;
    assign mem_size      = out_result.mem_size;
    assign load_unsigned = out_result.load_unsigned;
    assign store_data    = out_result.store_data;
    assign halt          = out_result.halt;

endmodule

@@ bench/tb_rv32i_decode_execute.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the RV32I decode and execute unit
// Drives instruction items through the push/full side and pops results on the
// empty/pop side. Each result is checked field by field against a table
// entry or an in-bench execute model. A directed table comes first, then
// weighted random items. Both sides idle at random, and the receiver also
// holds off for long stretches so that the unit fills and stalls its input.
// ============================================================================
module tb_rv32i_decode_execute;
    import rvde_pkg::*;

    localparam int RANDOM_ITEMS     = 780;
    localparam int QUIET_TAIL_ITEMS = 100;
    localparam int LONG_HOLD_CYCLES = 60;

    typedef struct {
        logic [31:0] word;
        logic [31:0] pc;
        logic [31:0] rs1v;
        logic [31:0] rs2v;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [31:0] instruction;
    logic [31:0] inst_pc;
    logic [31:0] src1_value;
    logic [31:0] src2_value;
    logic        empty;
    logic        pop;
    logic [2:0]  op_class;
    logic [4:0]  dest_reg;
    logic        writes_reg;
    logic [31:0] result_value;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic        load_unsigned;
    logic [31:0] store_data;
    logic        halt;

    result_t   pending_results[$];
    stim_row_t directed_table[$];
    int        mismatch_count      = 0;
    int        results_checked     = 0;
    int        stalled_push_cycles = 0;
    bit        idling_on           = 1'b1;

    rv32i_decode_execute uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .instruction   (instruction),
        .inst_pc       (inst_pc),
        .src1_value    (src1_value),
        .src2_value    (src2_value),
        .empty         (empty),
        .pop           (pop),
        .op_class      (op_class),
        .dest_reg      (dest_reg),
        .writes_reg    (writes_reg),
        .result_value  (result_value),
        .branch_taken  (branch_taken),
        .next_pc       (next_pc),
        .mem_address   (mem_address),
        .mem_size      (mem_size),
        .load_unsigned (load_unsigned),
        .store_data    (store_data),
        .halt          (halt)
    );

    always #6 clk = ~clk;

    // Expected result of one instruction item.
    function automatic result_t rv32i_execute(input logic [31:0] w, input logic [31:0] pc,
                                              input logic [31:0] a, input logic [31:0] b);
        result_t     r;
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [31:0] opnd;
        logic [31:0] alu_out;
        logic        ok;
        logic        wr;
        logic        cond;
        logic        imm_form;
        r = '0;
        r.op_class = CLS_INVALID;
        r.next_pc = pc + PC_STEP;
        opc = w[6:0];
        rd = w[11:7];
        f3 = w[14:12];
        f7 = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        wr = 1'b0;
        ok = 1'b1;
        cond = 1'b0;
        alu_out = '0;
        if (w == HALT_WORD)
        begin
            r.op_class = CLS_ALU;
            r.halt = 1'b1;
        end
        else
        begin
            case (opc)
                OPC_LUI:
                begin
                    r.op_class = CLS_ALU;
                    wr = 1'b1;
                    r.result_value = w & UIMM_MASK;
                end
                OPC_AUIPC:
                begin
                    r.op_class = CLS_ALU;
                    wr = 1'b1;
                    r.result_value = pc + (w & UIMM_MASK);
                end
                OPC_JAL:
                begin
                    r.op_class = CLS_JUMP;
                    wr = 1'b1;
                    r.result_value = pc + PC_STEP;
                    r.branch_taken = 1'b1;
                    r.next_pc = pc + imm_j;
                end
                OPC_JALR:
                begin
                    if (f3 == F3_JALR)
                    begin
                        r.op_class = CLS_JUMP;
                        wr = 1'b1;
                        r.result_value = pc + PC_STEP;
                        r.branch_taken = 1'b1;
                        r.next_pc = (a + imm_i) & ~32'h1;
                    end
                end
                OPC_BRANCH:
                begin
                    case (f3)
                        BR_EQ:   cond = (a == b);
                        BR_NE:   cond = (a != b);
                        BR_LT:   cond = ($signed(a) < $signed(b));
                        BR_GE:   cond = !($signed(a) < $signed(b));
                        BR_LTU:  cond = (a < b);
                        BR_GEU:  cond = (a >= b);
                        default: ok = 1'b0;
                    endcase
                    if (ok)
                    begin
                        r.op_class = CLS_BRANCH;
                        r.branch_taken = cond;
                        if (cond)
                            r.next_pc = pc + imm_b;
                    end
                end
                OPC_LOAD:
                begin
                    if (f3 != F3_LD_BAD && f3 <= F3_LD_HU)
                    begin
                        r.op_class = CLS_LOAD;
                        wr = 1'b1;
                        r.mem_address = a + imm_i;
                        r.mem_size = f3[1:0];
                        r.load_unsigned = f3[2];
                    end
                end
                OPC_STORE:
                begin
                    if (f3 <= F3_ST_W)
                    begin
                        r.op_class = CLS_STORE;
                        r.mem_address = a + imm_s;
                        r.mem_size = f3[1:0];
                        r.store_data = b;
                    end
                end
                OPC_OP_IMM, OPC_OP:
                begin
                    imm_form = (opc == OPC_OP_IMM);
                    opnd = imm_form ? imm_i : b;
                    case (f3)
                        F3_ADD:
                        begin
                            if (imm_form || f7 == F7_BASE)
                                alu_out = a + opnd;
                            else if (f7 == F7_ALT)
                                alu_out = a - opnd;
                            else
                                ok = 1'b0;
                        end
                        F3_SLL:
                        begin
                            if (f7 == F7_BASE)
                                alu_out = a << opnd[4:0];
                            else
                                ok = 1'b0;
                        end
                        F3_SR:
                        begin
                            if (f7 == F7_BASE)
                                alu_out = a >> opnd[4:0];
                            else if (f7 == F7_ALT)
                                alu_out = $signed(a) >>> opnd[4:0];
                            else
                                ok = 1'b0;
                        end
                        default:
                        begin
                            if (!imm_form && f7 != F7_BASE)
                                ok = 1'b0;
                            else
                            begin
                                case (f3)
                                    F3_SLT:  alu_out = {31'b0, $signed(a) < $signed(opnd)};
                                    F3_SLTU: alu_out = {31'b0, a < opnd};
                                    F3_XOR:  alu_out = a ^ opnd;
                                    F3_OR:   alu_out = a | opnd;
                                    default: alu_out = a & opnd;
                                endcase
                            end
                        end
                    endcase
                    if (ok)
                    begin
                        r.op_class = CLS_ALU;
                        wr = 1'b1;
                        r.result_value = alu_out;
                    end
                end
                default: ;
            endcase
        end
        if (wr)
            r.dest_reg = rd;
        r.writes_reg = wr && (rd != 5'd0);
        return r;
    endfunction

    function automatic result_t fixed_result(input logic [2:0] cls, input logic [4:0] dst,
                                             input logic wr, input logic [31:0] res,
                                             input logic [31:0] npc, input logic hlt);
        result_t r;
        r = '0;
        r.op_class = cls;
        r.dest_reg = dst;
        r.writes_reg = wr;
        r.result_value = res;
        r.next_pc = npc;
        r.halt = hlt;
        return r;
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [2:0] f3);
        return {imm[12], imm[10:5], 5'd2, 5'd1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    task automatic add_checked(input logic [31:0] w, input logic [31:0] pc,
                               input logic [31:0] a, input logic [31:0] b);
        stim_row_t row;
        row.word = w;
        row.pc = pc;
        row.rs1v = a;
        row.rs2v = b;
        row.typed = 1'b0;
        row.want = '0;
        directed_table.push_back(row);
    endtask

    task automatic add_typed(input logic [31:0] w, input logic [31:0] pc,
                             input logic [31:0] a, input logic [31:0] b, input result_t want);
        stim_row_t row;
        row.word = w;
        row.pc = pc;
        row.rs1v = a;
        row.rs2v = b;
        row.typed = 1'b1;
        row.want = want;
        directed_table.push_back(row);
    endtask

    function automatic logic [6:0] pick_funct7();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return F7_BASE;
        if (r < 9)
            return F7_ALT;
        return 7'($urandom());
    endfunction

    // Mostly well-formed words with random fields, plus near misses and noise.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 19))
            0: w[6:0] = OPC_LUI;
            1: w[6:0] = OPC_AUIPC;
            2: w[6:0] = OPC_JAL;
            3:
            begin
                w[6:0] = OPC_JALR;
                if ($urandom_range(0, 3) != 0)
                    w[14:12] = F3_JALR;
            end
            4, 5: w[6:0] = OPC_BRANCH;
            6, 7: w[6:0] = OPC_LOAD;
            8:
            begin
                w[6:0] = OPC_STORE;
                if ($urandom_range(0, 3) != 0)
                    w[14:12] = 3'($urandom_range(0, 2));
            end
            9, 10, 11:
            begin
                w[6:0] = OPC_OP_IMM;
                if (w[14:12] == F3_SLL || w[14:12] == F3_SR)
                    w[31:25] = pick_funct7();
            end
            12, 13, 14, 15:
            begin
                w[6:0] = OPC_OP;
                w[31:25] = pick_funct7();
            end
            16: w = HALT_WORD;
            17: ;
            18: w[1:0] = 2'b11;
            default: w = HALT_WORD ^ (32'd1 << $urandom_range(0, 31));
        endcase
        return w;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'($urandom_range(0, 64));
            default: return $urandom();
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    task automatic offer_item(input stim_row_t row);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        instruction <= row.word;
        inst_pc <= row.pc;
        src1_value <= row.rs1v;
        src2_value <= row.rs2v;
        @(posedge clk);
        while (full)
        begin
            stalled_push_cycles++;
            @(posedge clk);
        end
        pending_results.push_back(row.typed ? row.want
                                  : rv32i_execute(row.word, row.pc, row.rs1v, row.rs2v));
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Sender: reset, directed table, then random items.
    initial
    begin
        stim_row_t row;
        rst_n <= 1'b0;
        push <= 1'b0;
        instruction <= '0;
        inst_pc <= '0;
        src1_value <= '0;
        src2_value <= '0;

        add_typed(HALT_WORD, 32'h0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  fixed_result(CLS_ALU, 5'd0, 1'b0, 32'h0, 32'h0000_1004, 1'b1));
        add_typed(32'h0000_0000, 32'hFFFF_FFFC, 32'h1234_5678, 32'h0,
                  fixed_result(CLS_INVALID, 5'd0, 1'b0, 32'h0, 32'h0000_0000, 1'b0));
        add_typed(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  fixed_result(CLS_INVALID, 5'd0, 1'b0, 32'h0, 32'h8000_0004, 1'b0));
        add_typed({20'hFFFFF, 5'd31, OPC_LUI}, 32'h0, 32'h0, 32'h0,
                  fixed_result(CLS_ALU, 5'd31, 1'b1, 32'hFFFF_F000, 32'h4, 1'b0));
        add_checked({20'h80000, 5'd1, OPC_AUIPC}, 32'h8000_0010, 32'h0, 32'h0);
        add_checked(enc_j(21'h10_0000, 5'd0), 32'h0000_0010, 32'h0, 32'h0);
        add_checked(enc_j(21'h0F_FFFE, 5'd1), 32'hFFFF_FFF0, 32'h0, 32'h0);
        // The jump-and-link-register sum is odd here, so bit 0 of the target is cleared.
        add_checked(enc_i(12'hFFF, 5'd2, F3_JALR, 5'd5, OPC_JALR), 32'h40, 32'h0000_1002, 32'h0);
        add_typed(enc_i(12'h004, 5'd1, 3'd1, 5'd5, OPC_JALR), 32'h200, 32'h0, 32'h0,
                  fixed_result(CLS_INVALID, 5'd0, 1'b0, 32'h0, 32'h204, 1'b0));
        add_checked(enc_b(13'h1000, BR_EQ), 32'h800, 32'h8000_0000, 32'h8000_0000);
        add_checked(enc_b(13'h0FFE, BR_NE), 32'h800, 32'h8000_0000, 32'h7FFF_FFFF);
        add_checked(enc_b(13'h1000, BR_LT), 32'h800, 32'h8000_0000, 32'h7FFF_FFFF);
        add_checked(enc_b(13'h0FFE, BR_GE), 32'h800, 32'h8000_0000, 32'h7FFF_FFFF);
        add_checked(enc_b(13'h1000, BR_LTU), 32'h800, 32'h8000_0000, 32'h7FFF_FFFF);
        add_checked(enc_b(13'h0FFE, BR_GEU), 32'hFFFF_F000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_typed(enc_b(13'h0010, BR_RS2), 32'h300, 32'h0, 32'h0,
                  fixed_result(CLS_INVALID, 5'd0, 1'b0, 32'h0, 32'h304, 1'b0));
        add_typed(enc_b(13'h0010, BR_RS3), 32'h300, 32'h0, 32'h0,
                  fixed_result(CLS_INVALID, 5'd0, 1'b0, 32'h0, 32'h304, 1'b0));
        add_checked(enc_i(12'h800, 5'd1, 3'd0, 5'd7, OPC_LOAD), 32'h0, 32'h0, 32'h0);
        add_checked(enc_i(12'h7FF, 5'd1, F3_LD_HU, 5'd7, OPC_LOAD), 32'h0, 32'hFFFF_FFFF, 32'h0);
        add_checked(enc_i(12'h004, 5'd1, F3_LD_W, 5'd0, OPC_LOAD), 32'h0, 32'h1000, 32'h0);
        add_typed(enc_i(12'h004, 5'd1, F3_LD_BAD, 5'd7, OPC_LOAD), 32'h500, 32'h1000, 32'h0,
                  fixed_result(CLS_INVALID, 5'd0, 1'b0, 32'h0, 32'h504, 1'b0));
        add_checked(enc_s(12'h800, 5'd2, 5'd1, 3'd0), 32'h0, 32'h100, 32'hDEAD_BEEF);
        add_checked(enc_s(12'h7FF, 5'd2, 5'd1, F3_ST_W), 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_typed(enc_s(12'h010, 5'd2, 5'd1, 3'd3), 32'h600, 32'h100, 32'hDEAD_BEEF,
                  fixed_result(CLS_INVALID, 5'd0, 1'b0, 32'h0, 32'h604, 1'b0));
        add_checked(enc_i(12'h800, 5'd1, F3_ADD, 5'd3, OPC_OP_IMM), 32'h0, 32'h7FFF_FFFF, 32'h0);
        add_checked(enc_i({F7_BASE, 5'd31}, 5'd1, F3_SLL, 5'd3, OPC_OP_IMM), 32'h0,
                    32'hFFFF_FFFF, 32'h0);
        add_checked(enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd3, OPC_OP_IMM), 32'h0,
                    32'h8000_0000, 32'h0);
        add_typed(enc_i({F7_ALT, 5'd1}, 5'd1, F3_SLL, 5'd3, OPC_OP_IMM), 32'h700, 32'h1, 32'h0,
                  fixed_result(CLS_INVALID, 5'd0, 1'b0, 32'h0, 32'h704, 1'b0));
        // Every register operation; the shift amount only uses the low five bits of rs2.
        for (int k = 0; k < 8; k++)
            add_checked(enc_r(F7_BASE, 5'd2, 5'd1, k[2:0], 5'd3, OPC_OP), 32'h0,
                        32'hF0F0_F0F0, 32'hFF00_FFE1);
        add_checked(enc_r(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP), 32'h0, 32'h0, 32'h1);
        add_checked(enc_r(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd3, OPC_OP), 32'h0,
                    32'h8000_0000, 32'hFFFF_FFE1);
        add_typed(enc_r(F7_ALT, 5'd2, 5'd1, F3_OR, 5'd3, OPC_OP), 32'h900, 32'h1, 32'h2,
                  fixed_result(CLS_INVALID, 5'd0, 1'b0, 32'h0, 32'h904, 1'b0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
            offer_item(directed_table[i]);

        // Hold the input until the unit has handed back everything.
        push <= 1'b0;
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                push <= 1'b0;
                wait_for_drain();
            end
            if (n == RANDOM_ITEMS - QUIET_TAIL_ITEMS)
                idling_on = 1'b0;
            row.word = random_word();
            row.pc = $urandom();
            if ($urandom_range(0, 3) != 0)
                row.pc[1:0] = 2'b00;
            row.rs1v = random_value();
            row.rs2v = ($urandom_range(0, 4) == 0) ? row.rs1v : random_value();
            row.typed = 1'b0;
            row.want = '0;
            offer_item(row);
        end
        push <= 1'b0;

        wait_for_drain();
        repeat (8) @(posedge clk);
        $display("Ran %0d directed and %0d random instructions; %0d results checked.",
                 directed_table.size(), RANDOM_ITEMS, results_checked);
        $display("Input was held off by full for %0d cycles.", stalled_push_cycles);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: pops with random bursts of idling and two long hold-offs.
    initial
    begin
        int      stall_left;
        result_t want;
        stall_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item popped with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("op_class", 32'(want.op_class), 32'(op_class));
                    compare_field("dest_reg", 32'(want.dest_reg), 32'(dest_reg));
                    compare_field("writes_reg", 32'(want.writes_reg), 32'(writes_reg));
                    compare_field("result_value", want.result_value, result_value);
                    compare_field("branch_taken", 32'(want.branch_taken), 32'(branch_taken));
                    compare_field("next_pc", want.next_pc, next_pc);
                    compare_field("mem_address", want.mem_address, mem_address);
                    compare_field("mem_size", 32'(want.mem_size), 32'(mem_size));
                    compare_field("load_unsigned", 32'(want.load_unsigned), 32'(load_unsigned));
                    compare_field("store_data", want.store_data, store_data);
                    compare_field("halt", 32'(want.halt), 32'(halt));
                end
                results_checked++;
                if (results_checked == 120 || results_checked == 450)
                    stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
